>>> hdl/nmea_altitude_field_parser_defines.svh
// assertion macros shared by the nmea altitude field parser modules
// no dependencies; included by the modules that carry assertions
`ifndef NMEA_ALTITUDE_FIELD_PARSER_DEFINES_SVH
`define NMEA_ALTITUDE_FIELD_PARSER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define NAFP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define NAFP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/nafp_pkg.sv
// shared types, character codes and constants for the nmea altitude field parser
// no dependencies; imported by every module of the block
`default_nettype none

package nafp_pkg;

   // ascii codes the parser reacts to
   localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_POINT   = 8'h2E;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   // configuration and sizing
   localparam int unsigned FIELD_NUM_W         = 5;
   localparam logic [FIELD_NUM_W-1:0] FIELD_NUMBER_RESET = 5'd9;
   localparam logic [FIELD_NUM_W-1:0] COMMA_COUNT_MAX    = 5'd31;
   localparam int unsigned FIELD_CHARS_MAX_DEFAULT = 11;

   // magnitude in thousandths, capped at 2^31
   localparam int unsigned ACC_W   = 32;
   localparam int unsigned WIDE_W  = 36;
   localparam logic [ACC_W-1:0] MAG_CAP = 32'h8000_0000;
   localparam logic [ACC_W-1:0] POS_MAX = 32'h7FFF_FFFF;
   localparam logic [1:0] FRAC_DIGITS_MAX = 2'd3;

   // byte handed from the input register to the parser
   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
   } byte_stage_type;

   // one result request
   typedef struct packed {
      logic signed [ACC_W-1:0] altitude_milli;
      logic                    field_found;
   } result_type;

   // weight of a fractional digit in thousandths
   function automatic logic [6:0] frac_weight(input logic [1:0] pos);
      logic [6:0] w;
      unique case (pos)
         2'd0:    w = 7'd100;
         2'd1:    w = 7'd10;
         default: w = 7'd1;
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

>>> hdl/nafp_in_stage.sv
// input register for received bytes, with valid/ready toward the source
// depends on nafp_pkg
`default_nettype none

module nafp_in_stage
   import nafp_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire logic [7:0]     req_rx_byte,
   input  wire logic           advance,
   output byte_stage_type      stage
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       req_fire;

   // room when empty or when the parser drains the held byte
   assign req_ready = !valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (req_fire) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_fire) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign stage.valid   = valid_ff;
   assign stage.rx_byte = byte_ff;

endmodule

`default_nettype wire

>>> hdl/nafp_parser.sv
// sentence tracking, field conversion to thousandths and the result register
// depends on nafp_pkg and nmea_altitude_field_parser_defines.svh
`default_nettype none

`include "nmea_altitude_field_parser_defines.svh"

module nafp_parser
   import nafp_pkg::*;
#(
   parameter int unsigned FIELD_CHARS_MAX = FIELD_CHARS_MAX_DEFAULT
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [FIELD_NUM_W-1:0] field_number,
   input  wire byte_stage_type         stage,
   output logic                        advance,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output result_type                  result
);

   localparam int unsigned CNT_W = $clog2(FIELD_CHARS_MAX + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(FIELD_CHARS_MAX);

   // sentence and conversion state
   logic                   in_sentence_ff, in_sentence_in;
   logic [FIELD_NUM_W-1:0] comma_ff, comma_in;
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic [1:0]             frac_ff, frac_in;
   logic                   point_ff, point_in;
   logic                   minus_ff, minus_in;
   logic                   stopped_ff, stopped_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             result_ff, result_in;

   logic             fire;
   logic [7:0]       c;
   logic             in_field;
   logic             emit;
   logic             emit_found;
   logic             is_digit;
   logic [3:0]       digit;
   logic [WIDE_W-1:0] acc_wide;
   logic [WIDE_W-1:0] acc_sum;
   logic [ACC_W-1:0] emit_value;

   assign advance  = !rsp_valid_ff || rsp_ready;
   assign fire     = stage.valid && advance;
   assign c        = stage.rx_byte;
   assign in_field = (comma_ff == field_number);
   assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   assign digit    = 4'(c - CHAR_ZERO);
   assign acc_wide = {{(WIDE_W-ACC_W){1'b0}}, acc_ff};

   // digit accumulate: shift in an integer digit or add a weighted fraction digit
   always_comb begin
      if (!point_ff) begin
         acc_sum = (acc_wide << 3) + (acc_wide << 1)
                 + WIDE_W'(14'(digit) * 14'd1000);
      end else if (frac_ff < FRAC_DIGITS_MAX) begin
         acc_sum = acc_wide + WIDE_W'(11'(digit) * 11'(frac_weight(frac_ff)));
      end else begin
         acc_sum = acc_wide;
      end
   end

   // signed, saturated result value
   always_comb begin
      if (!emit_found) begin
         emit_value = '0;
      end else if (minus_ff) begin
         emit_value = ACC_W'(0) - acc_ff;
      end else if (acc_ff[ACC_W-1]) begin
         emit_value = POS_MAX;
      end else begin
         emit_value = acc_ff;
      end
   end

   // per-byte state update
   always_comb begin
      in_sentence_in = in_sentence_ff;
      comma_in       = comma_ff;
      acc_in         = acc_ff;
      frac_in        = frac_ff;
      point_in       = point_ff;
      minus_in       = minus_ff;
      stopped_in     = stopped_ff;
      cnt_in         = cnt_ff;
      emit           = 1'b0;
      emit_found     = 1'b0;
      if (fire) begin
         if (c == CHAR_DOLLAR) begin
            in_sentence_in = 1'b1;
            comma_in       = '0;
            acc_in         = '0;
            frac_in        = '0;
            point_in       = 1'b0;
            minus_in       = 1'b0;
            stopped_in     = 1'b0;
            cnt_in         = '0;
         end else if (in_sentence_ff) begin
            if (c == CHAR_STAR || c == CHAR_NEWLINE) begin
               emit       = 1'b1;
               emit_found = in_field;
            end else if (c == CHAR_COMMA) begin
               if (in_field) begin
                  emit       = 1'b1;
                  emit_found = 1'b1;
               end else if (comma_ff < COMMA_COUNT_MAX) begin
                  comma_in = comma_ff + 1'b1;
               end
            end else if (in_field && cnt_ff < CNT_MAX) begin
               cnt_in = cnt_ff + 1'b1;
               if (!stopped_ff) begin
                  priority if (is_digit) begin
                     acc_in = (acc_sum > WIDE_W'(MAG_CAP)) ? MAG_CAP : ACC_W'(acc_sum);
                     if (point_ff && frac_ff < FRAC_DIGITS_MAX) begin
                        frac_in = frac_ff + 1'b1;
                     end
                  end else if (c == CHAR_POINT && !point_ff) begin
                     point_in = 1'b1;
                  end else if ((c == CHAR_MINUS || c == CHAR_PLUS) && cnt_ff == '0) begin
                     minus_in = (c == CHAR_MINUS);
                  end else begin
                     stopped_in = 1'b1;
                  end
               end
            end
         end
      end
      if (emit) begin
         in_sentence_in = 1'b0;
      end
   end

   // result register: load on emit, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      result_in    = result_ff;
      if (emit) begin
         rsp_valid_in             = 1'b1;
         result_in.altitude_milli = emit_value;
         result_in.field_found    = emit_found;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_sentence_ff <= 1'b0;
         comma_ff       <= '0;
         acc_ff         <= '0;
         frac_ff        <= '0;
         point_ff       <= 1'b0;
         minus_ff       <= 1'b0;
         stopped_ff     <= 1'b0;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         in_sentence_ff <= in_sentence_in;
         comma_ff       <= comma_in;
         acc_ff         <= acc_in;
         frac_ff        <= frac_in;
         point_ff       <= point_in;
         minus_ff       <= minus_in;
         stopped_ff     <= stopped_in;
         cnt_ff         <= cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

   // checks
   `NAFP_ASSERT_IMP(a_mag_capped, clock, reset, 1'b1, acc_ff <= MAG_CAP, "magnitude above cap")
   `NAFP_ASSERT_IMP(a_frac_after_point, clock, reset, frac_ff != 2'd0, point_ff, "fraction digits without point")
   `NAFP_ASSERT_IMP(a_char_bound, clock, reset, 1'b1, cnt_ff <= CNT_MAX, "field char count overrun")
   `NAFP_ASSERT_NEXT(a_emit_ends_sentence, clock, reset, emit, !in_sentence_ff && rsp_valid_ff, "emit did not close sentence")

endmodule

`default_nettype wire

>>> hdl/nmea_altitude_field_parser.sv
// A byte accepted into the input register is parsed from there, and a result it closes is
// loaded into the result register, which drives rsp_valid.
// Throughput: one byte per cycle; the input stalls only while a result waits on rsp_ready.
// Reset is synchronous, active high: field_number returns to 9, the parser waits for '$',
// and both the input and result registers are emptied.
// top level: config register, input register and parser; depends on nafp_pkg, nafp_in_stage,
// nafp_parser
`default_nettype none

module nmea_altitude_field_parser
   import nafp_pkg::*;
#(
   parameter int unsigned FIELD_CHARS_MAX = FIELD_CHARS_MAX_DEFAULT
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [FIELD_NUM_W-1:0] csr_field_number,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [7:0]             req_rx_byte,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic signed [ACC_W-1:0]     rsp_altitude_milli,
   output logic                        rsp_field_found
);

   logic [FIELD_NUM_W-1:0] field_number_ff, field_number_in;
   byte_stage_type         stage;
   logic                   advance;
   result_type             result;

   // field select register, always writable
   assign csr_ready = 1'b1;
   assign field_number_in = (csr_valid && csr_ready) ? csr_field_number : field_number_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_number_ff <= FIELD_NUMBER_RESET;
      end else begin
         field_number_ff <= field_number_in;
      end
   end

   // input register
   nafp_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .stage       (stage)
   );

   // parser and result register
   nafp_parser #(
      .FIELD_CHARS_MAX (FIELD_CHARS_MAX)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .field_number (field_number_ff),
      .stage        (stage),
      .advance      (advance),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .result       (result)
   );

   assign rsp_altitude_milli = result.altitude_milli;
   assign rsp_field_found    = result.field_found;

endmodule

`default_nettype wire

>>> tb/tb_nmea_altitude_field_parser.sv
// self-checking testbench for the nmea altitude field parser: byte stream in, field value out
// depends on nafp_pkg and nmea_altitude_field_parser; predicts each result from its own parser
`default_nettype none

module tb_nmea_altitude_field_parser
   import nafp_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD     = 8;
   localparam int RESET_CYCLES   = 6;
   localparam int FIELD_CHARS    = FIELD_CHARS_MAX_DEFAULT;
   localparam int DRAIN_CYCLES   = 4;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SEGMENTS       = 12;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [FIELD_NUM_W-1:0]    csr_field_number = '0;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [7:0]                req_rx_byte = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [ACC_W-1:0]   rsp_altitude_milli;
   logic                      rsp_field_found;

   // byte stream waiting to be sent, and parsed values still to arrive
   logic [7:0]  byte_stream[$];
   result_type  alt_results_due[$];

   int send_idle_pct = 17;
   int recv_idle_pct = 73;
   int hold_requests = 0;
   int holds_served  = 0;
   int hold_left     = 0;
   int stall_cycles  = 0;
   int error_count   = 0;
   int results_checked = 0;
   int bytes_accepted  = 0;
   int bytes_queued    = 0;
   int cfg_writes      = 0;
   logic [FIELD_NUM_W-1:0] cfg_now = FIELD_NUMBER_RESET;

   // parser state of the predictor
   logic [FIELD_NUM_W-1:0] fld_sel;
   bit          in_sent;
   logic [4:0]  commas;
   logic [31:0] mag;
   logic [1:0]  fracs;
   bit          point_taken;
   bit          minus_taken;
   bit          stopped;
   logic [3:0]  nchars;

   nmea_altitude_field_parser DUT (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_field_number   (csr_field_number),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_altitude_milli (rsp_altitude_milli),
      .rsp_field_found    (rsp_field_found)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic void open_sentence();
      in_sent     = 1'b1;
      commas      = '0;
      mag         = '0;
      fracs       = '0;
      point_taken = 1'b0;
      minus_taken = 1'b0;
      stopped     = 1'b0;
      nchars      = '0;
   endfunction

   // one character of the wanted field, atof style
   function automatic void take_field_char(input logic [7:0] c);
      bit          first;
      logic [63:0] wide;
      logic [63:0] d;
      first = (nchars == 0);
      if (nchars < FIELD_CHARS) begin
         nchars++;
         if (!stopped) begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
               d    = c - CHAR_ZERO;
               wide = mag;
               if (!point_taken) begin
                  wide = wide * 10 + d * 1000;
               end else if (fracs < FRAC_DIGITS_MAX) begin
                  wide = wide + d * ((fracs == 2'd0) ? 100 : (fracs == 2'd1) ? 10 : 1);
                  fracs++;
               end
               mag = (wide > MAG_CAP) ? MAG_CAP : wide[31:0];
            end else if (c == CHAR_POINT && !point_taken) begin
               point_taken = 1'b1;
            end else if ((c == CHAR_MINUS || c == CHAR_PLUS) && first) begin
               minus_taken = (c == CHAR_MINUS);
            end else begin
               stopped = 1'b1;
            end
         end
      end
   endfunction

   // value of the finished field, sign applied and clamped
   function automatic result_type close_sentence(input bit found);
      result_type r;
      r = '0;
      if (found) begin
         if (minus_taken) begin
            r.altitude_milli = -mag;
         end else begin
            r.altitude_milli = (mag > POS_MAX) ? POS_MAX : mag;
         end
      end
      r.field_found = found;
      in_sent = 1'b0;
      return r;
   endfunction

   // returns 1 when the character ends the sentence, with its result in r
   function automatic bit parse_char(input logic [7:0] c, output result_type r);
      bit here;
      r    = '0;
      here = (commas == fld_sel);
      if (c == CHAR_DOLLAR) begin
         open_sentence();
         return 1'b0;
      end
      if (!in_sent) begin
         return 1'b0;
      end
      if (c == CHAR_STAR || c == CHAR_NEWLINE) begin
         r = close_sentence(here);
         return 1'b1;
      end
      if (c == CHAR_COMMA) begin
         if (here) begin
            r = close_sentence(1'b1);
            return 1'b1;
         end
         if (commas != COMMA_COUNT_MAX) begin
            commas++;
         end
         return 1'b0;
      end
      if (here) begin
         take_field_char(c);
      end
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------- driver

   // next byte goes out when the line is free, with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (byte_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid   <= 1'b1;
            req_rx_byte <= byte_stream.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver back-pressure, with an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (holds_served != hold_requests) begin
         holds_served <= holds_served + 1;
         hold_left    <= HOLD_CYCLES;
         rsp_ready    <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin : monitor_blk
      result_type due;
      result_type pred;
      bit         made;
      if (reset) begin
         fld_sel = FIELD_NUMBER_RESET;
         open_sentence();
         in_sent = 1'b0;
      end else begin
         // check the result request against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (alt_results_due.size() == 0) begin
               $error("result with none pending: altitude_milli %0d field_found %0d",
                      rsp_altitude_milli, rsp_field_found);
               error_count++;
            end else begin
               due = alt_results_due.pop_front();
               results_checked++;
               if (rsp_altitude_milli !== due.altitude_milli) begin
                  $error("altitude_milli: expected %0d, got %0d",
                         due.altitude_milli, rsp_altitude_milli);
                  error_count++;
               end
               if (rsp_field_found !== due.field_found) begin
                  $error("field_found: expected %0d, got %0d",
                         due.field_found, rsp_field_found);
                  error_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            fld_sel = csr_field_number;
         end
         // predict from each accepted byte
         if (req_valid && req_ready) begin
            bytes_accepted++;
            made = parse_char(req_rx_byte, pred);
            if (made) begin
               alt_results_due.push_back(pred);
            end
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("no handshake for %0d cycles, %0d results outstanding",
                  stall_cycles, alt_results_due.size());
         $display("TB_ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic push_byte(input logic [7:0] b);
      byte_stream.push_back(b);
      bytes_queued++;
   endtask

   task automatic push_text(input string t);
      for (int i = 0; i < t.len(); i++) begin
         push_byte(t[i]);
      end
   endtask

   task automatic push_digit();
      push_byte(CHAR_ZERO + 8'($urandom_range(9)));
   endtask

   // any byte that does not frame a sentence
   function automatic logic [7:0] junk_byte();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(255));
      end while (b inside {CHAR_DOLLAR, CHAR_COMMA, CHAR_STAR, CHAR_NEWLINE});
      return b;
   endfunction

   // short content of a field that is not the wanted one
   task automatic push_filler();
      string pool;
      pool = "0123456789.NSEWMK";
      repeat ($urandom_range(0, 3)) push_byte(pool[$urandom_range(pool.len() - 1)]);
   endtask

   // decimal text for the wanted field
   task automatic push_number();
      string mess;
      mess = "0123456789.+-.9";
      if ($urandom_range(9) == 0) begin
         // loose mix of number characters, often past the field limit
         repeat ($urandom_range(1, 15)) push_byte(mess[$urandom_range(mess.len() - 1)]);
      end else begin
         case ($urandom_range(3))
            0: push_byte(CHAR_MINUS);
            1: push_byte(CHAR_PLUS);
            default: ;
         endcase
         if ($urandom_range(7) == 0) begin
            repeat ($urandom_range(6, 12)) push_digit();
         end else begin
            repeat ($urandom_range(0, 4)) push_digit();
         end
         if ($urandom_range(3) != 0) begin
            push_byte(CHAR_POINT);
            repeat ($urandom_range(0, 5)) push_digit();
         end
         if ($urandom_range(4) == 0) begin
            push_byte(junk_byte());
            repeat ($urandom_range(0, 2)) push_digit();
         end
      end
   endtask

   // well-formed sentence; some end before the selected field, the rest carry a value in it
   task automatic push_gga_sentence();
      int n_fields;
      if ($urandom_range(9) == 0) begin
         n_fields = $urandom_range(0, cfg_now);
      end else begin
         n_fields = cfg_now + $urandom_range(0, 2);
      end
      push_byte(CHAR_DOLLAR);
      if (cfg_now == 0) begin
         push_number();
      end else begin
         push_text("GPGGA");
      end
      for (int k = 1; k <= n_fields; k++) begin
         push_byte(CHAR_COMMA);
         if (k == cfg_now) begin
            push_number();
         end else begin
            push_filler();
         end
      end
      case ($urandom_range(2))
         0: push_text("*4F\r\n");
         1: push_byte(CHAR_NEWLINE);
         default: push_byte(CHAR_STAR);
      endcase
   endtask

   // line noise, abandoned sentences and random garbage sentences
   task automatic push_broken();
      logic [7:0] b;
      case ($urandom_range(2))
         0: begin
            repeat ($urandom_range(1, 8)) begin
               do begin
                  b = 8'($urandom_range(255));
               end while (b == CHAR_DOLLAR);
               push_byte(b);
            end
         end
         1: begin
            push_byte(CHAR_DOLLAR);
            push_text("GPGGA");
            repeat ($urandom_range(0, cfg_now)) begin
               push_byte(CHAR_COMMA);
               push_filler();
            end
         end
         default: begin
            push_byte(CHAR_DOLLAR);
            repeat ($urandom_range(4, 20)) push_byte(8'($urandom_range(255)));
            push_byte(CHAR_NEWLINE);
         end
      endcase
   endtask

   // block idle: nothing queued, nothing in flight, all results in
   task automatic wait_quiet();
      do begin
         @(posedge clock);
      end while (byte_stream.size() != 0 || req_valid || alt_results_due.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_field_number(input logic [FIELD_NUM_W-1:0] v);
      @(posedge clock);
      csr_valid        <= 1'b1;
      csr_field_number <= v;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
      cfg_now = v;
      cfg_writes++;
   endtask

   initial begin : stimulus_blk
      string directed[$];
      int    cfg_plan[SEGMENTS];
      int    seg_start;
      int    good;
      directed = '{"xy,*\n", "$H,123.456*", "$H,-0.5\n", "$H,+7,x", "$H,*", "$H,-*",
                   "$H,-0*", "$H,1.23456*", "$H,12.3.4*", "$H,5-3*",
                   "$H,123456789012345*", "$H,-9999999999*", "$H,2147483.647*",
                   "$H,2147483.648*", "$H*", "$H\n", "$H,12$H,34*", "$H,1a2*",
                   "$H,.5*", "$H,7.*", "$H,+-3*"};
      cfg_plan = '{9, 0, 31, 3, 1, 30, 2, 0, 9, 4, 5, 17};

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed sentences on field 1: signs, points, limits, framing
      write_field_number(5'd1);
      foreach (directed[i]) push_text(directed[i]);
      push_text("$H,4");
      push_byte(8'hFF);
      push_text("9*$H,8");
      push_byte(8'h00);
      push_byte(8'h80);
      push_text("1\n");
      wait_quiet();

      // count runs past a lowered field number and saturates
      write_field_number(5'd31);
      push_text("$H");
      repeat (20) push_byte(CHAR_COMMA);
      wait_quiet();
      write_field_number(5'd5);
      repeat (20) push_byte(CHAR_COMMA);
      push_byte(CHAR_NEWLINE);
      wait_quiet();

      // field number moved below the count mid-sentence
      write_field_number(5'd9);
      push_text("$H,1,2,3");
      wait_quiet();
      write_field_number(5'd2);
      push_byte(CHAR_STAR);
      wait_quiet();

      // field number moved ahead of the count mid-sentence
      write_field_number(5'd9);
      push_text("$H,1");
      wait_quiet();
      write_field_number(5'd2);
      push_text(",-4.25*");
      wait_quiet();

      // field number moved onto the current field
      write_field_number(5'd9);
      push_text("$H,1,2,3.5");
      wait_quiet();
      write_field_number(5'd3);
      push_text("7*");
      wait_quiet();

      // random sentences: three idling modes, four field settings each
      for (int s = 0; s < SEGMENTS; s++) begin
         if (s == 4) begin
            send_idle_pct = 73;
            recv_idle_pct = 17;
         end else if (s == 8) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_field_number((s == 7) ? 5'($urandom_range(31)) : 5'(cfg_plan[s]));
         seg_start = bytes_queued;
         good      = 0;
         while (bytes_queued - seg_start < 100 || good < 2) begin
            if ($urandom_range(99) < 80) begin
               push_gga_sentence();
               good++;
            end else begin
               push_broken();
            end
         end
         // receiver holds off while the sender keeps streaming
         if (s == 8) begin
            hold_requests++;
         end
         wait_quiet();
      end

      $display("%0d bytes sent, %0d field values checked, %0d field number writes",
               bytes_accepted, results_checked, cfg_writes);
      $display("covered signs, points, truncation, saturation, restarts and mid-sentence writes");
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
